// ===== rtl/core/tvfd_pkg.sv =====
// tvfd_pkg: shared types and constants for the touch/volume frame decoder
// no dependencies; used by every module in rtl/core

package tvfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned SUM_W       = 7;
  localparam int unsigned POT_W       = 7;
  localparam int unsigned Y_W         = 10;
  localparam int unsigned X_W         = 11;
  localparam int unsigned VOL_W       = 9;
  localparam int unsigned LAST_VOL_W  = 10;
  localparam int unsigned STEPS_W     = 8;

  localparam logic [POS_W-1:0]      LAST_DATA_POS = 3'd4;
  localparam logic [X_W-1:0]        X_BASE        = 11'd1024;
  localparam logic [SUM_W-1:0]      POT_FULL      = 7'd127;
  localparam logic [LAST_VOL_W-1:0] NO_VOLUME     = 10'h3ff;
  localparam logic [STEPS_W-1:0]    STEPS_RESET   = 8'd21;

  typedef struct packed {
    logic             done;
    logic             ok;
    logic             bad;
    logic             lost;
    logic             pressed;
    logic [Y_W-1:0]   y;
    logic [X_W-1:0]   x;
    logic [POT_W-1:0] pot;
  } frame_t;

endpackage

// ===== rtl/core/touch_volume_frame_decoder.sv =====
// Decodes five-byte touch/volume frames from a received byte stream. Each accepted byte
// gives exactly one result transaction, registered first in the input register and then in
// the result register; one byte per cycle is sustained while out_ready stays high. These
// two registers bracket a single pass of deframing, checksum compare and volume scaling,
// and while a result is held, a new byte enters the input register only if it is empty.
// Depends on tvfd_pkg, tvfd_deframer and tvfd_volume.

module touch_volume_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tvfd_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tvfd_pkg::STEPS_W-1:0]  cfg_volume_steps,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_done,
  output logic                          out_frame_ok,
  output logic                          out_checksum_error,
  output logic                          out_sync_lost,
  output logic                          out_touch_pressed,
  output logic [tvfd_pkg::Y_W-1:0]      out_touch_y,
  output logic [tvfd_pkg::X_W-1:0]      out_touch_x,
  output logic [tvfd_pkg::VOL_W-1:0]    out_volume,
  output logic                          out_volume_changed
);

  logic                          hold_valid_r;
  logic [tvfd_pkg::BYTE_W-1:0]   hold_byte_r;
  logic [tvfd_pkg::STEPS_W-1:0]  steps_r;
  logic                          out_valid_r;
  logic                          out_free;
  logic                          step;
  tvfd_pkg::frame_t              frame;
  logic [tvfd_pkg::VOL_W-1:0]    vol;
  logic                          vol_chg;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = hold_valid_r && out_free;
  assign in_ready  = !hold_valid_r || out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      steps_r      <= tvfd_pkg::STEPS_RESET;
    end else begin
      if (in_ready) begin
        hold_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= hold_valid_r;
      end
      if (cfg_valid) begin
        steps_r <= cfg_volume_steps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_rx_byte;
    end
  end

  tvfd_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (hold_byte_r),
    .frame   (frame)
  );

  tvfd_volume u_volume (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .frame_ok (frame.ok),
    .pot      (frame.pot),
    .steps    (steps_r),
    .volume   (vol),
    .changed  (vol_chg)
  );

  always_ff @(posedge clk) begin
    if (step) begin
      out_frame_done     <= frame.done;
      out_frame_ok       <= frame.ok;
      out_checksum_error <= frame.bad;
      out_sync_lost      <= frame.lost;
      out_touch_pressed  <= frame.pressed;
      out_touch_y        <= frame.y;
      out_touch_x        <= frame.x;
      out_volume         <= vol;
      out_volume_changed <= vol_chg;
    end
  end

  a_ok_xor_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_done |-> (out_frame_ok != out_checksum_error))
    else $error("completed frame must be either good or bad");

  a_flags_need_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_frame_done |-> !out_frame_ok && !out_checksum_error)
    else $error("frame status without completed frame");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_frame_ok |->
      out_touch_x == '0 && out_touch_y == '0 && !out_touch_pressed)
    else $error("touch fields set without good frame");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_touch_x) && $stable(out_volume))
    else $error("held result lost or changed");

endmodule

// ===== rtl/core/tvfd_deframer.sv =====
// tvfd_deframer: byte position, running checksum and frame byte store
// depends on tvfd_pkg; result is combinational from state and current byte

module tvfd_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [tvfd_pkg::BYTE_W-1:0]   rx_byte,
  output tvfd_pkg::frame_t              frame
);

  logic [tvfd_pkg::POS_W-1:0]  pos_r, pos_nxt, pos_eff;
  logic [tvfd_pkg::SUM_W-1:0]  sum_r, sum_nxt, sum_eff;
  logic [tvfd_pkg::BYTE_W-1:0] bytes_r [4];
  logic                        is_sync;
  logic                        store;
  logic                        match;

  assign is_sync = rx_byte[7];
  assign pos_eff = is_sync ? '0 : pos_r;
  assign sum_eff = is_sync ? '0 : sum_r;
  assign store   = (pos_eff < tvfd_pkg::LAST_DATA_POS);
  assign match   = ({1'b0, sum_eff} == rx_byte);
  assign sum_nxt = sum_eff + rx_byte[tvfd_pkg::SUM_W-1:0];
  assign pos_nxt = store ? pos_eff + 3'd1 : '0;

  always_comb begin
    frame         = '0;
    frame.lost    = is_sync && (pos_r != '0);
    frame.done    = !store;
    frame.ok      = !store && match;
    frame.bad     = !store && !match;
    if (frame.ok) begin
      frame.pressed = bytes_r[0][6];
      frame.y       = {bytes_r[0][5:0], bytes_r[1][6:3]};
      frame.x       = tvfd_pkg::X_BASE - {1'b0, bytes_r[1][2:0], bytes_r[2][6:0]};
      frame.pot     = bytes_r[3][6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store) begin
      bytes_r[pos_eff[1:0]] <= rx_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= tvfd_pkg::LAST_DATA_POS)
    else $error("byte position out of range");

  a_sync_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_sync |=> pos_r == 3'd1)
    else $error("sync byte did not restart frame");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && frame.done |=> pos_r == '0)
    else $error("position not cleared after fifth byte");

endmodule

// ===== rtl/core/tvfd_volume.sv =====
// tvfd_volume: pot scaling by (steps+1)/127 and volume change tracking
// depends on tvfd_pkg; divide by 127 done as shift plus small correction

module tvfd_volume (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           frame_ok,
  input  logic [tvfd_pkg::POT_W-1:0]     pot,
  input  logic [tvfd_pkg::STEPS_W-1:0]   steps,
  output logic [tvfd_pkg::VOL_W-1:0]     volume,
  output logic                           changed
);

  logic [tvfd_pkg::STEPS_W:0]      scale;
  logic [14:0]                     prod;
  logic [7:0]                      quo_hi;
  logic [8:0]                      rem;
  logic [1:0]                      fix;
  logic [tvfd_pkg::VOL_W-1:0]      vol;
  logic [tvfd_pkg::LAST_VOL_W-1:0] last_r;

  // p = 128*a + lo = 127*a + (a + lo), and a + lo stays below 3*127
  assign scale  = {1'b0, steps} + 9'd1;
  assign prod   = {8'd0, pot} * {6'd0, scale};
  assign quo_hi = prod[14:7];
  assign rem    = {1'b0, quo_hi} + {2'b00, prod[6:0]};
  assign fix    = (rem >= {1'b0, tvfd_pkg::POT_FULL, 1'b0}) ? 2'd2 :
                  (rem >= {2'b00, tvfd_pkg::POT_FULL})      ? 2'd1 : 2'd0;
  assign vol    = {1'b0, quo_hi} + {7'd0, fix};

  assign volume  = frame_ok ? vol : '0;
  assign changed = frame_ok && ({1'b0, vol} != last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= tvfd_pkg::NO_VOLUME;
    end else if (step && changed) begin
      last_r <= {1'b0, vol};
    end
  end

  a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    step && changed |=> last_r == {1'b0, $past(vol)})
    else $error("last volume not updated");

  a_vol_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_ok |-> vol <= {1'b0, scale[tvfd_pkg::STEPS_W:1], scale[0]})
    else $error("volume above steps plus one");

  a_no_change_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_ok |-> !changed && volume == '0)
    else $error("volume reported without good frame");

endmodule
